@@ hdl/odm_pkg.sv @@
// ----------------------------------------------------------------------------
// odm_pkg: shared types, constants and the sine-table builder
// Opcodes, the degree-table entry function in Q1.TRIG_FRAC_BITS and the weight constants.
// ----------------------------------------------------------------------------
package odm_pkg;

    localparam int TRIG_FRAC_BITS_DEF = 15;
    localparam int WEIGHT_SIN = 819;
    localparam int WEIGHT_COS = 574;

    typedef enum logic [2:0] {
        OP_DIRECT = 3'd0,
        OP_VECTOR = 3'd1,
        OP_STOP   = 3'd2,
        OP_CHASE  = 3'd3,
        OP_FACE   = 3'd4
    } t_opcode;

    // sin(d) magnitude, d in 0..90, built with an integer Taylor series in Q30 radians
    function automatic logic [20:0] sin_entry(input int d, input int frac);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] t2;
        longint      sum;
        longint      res;
        x    = 64'(d) * 64'd18740330;
        term = x;
        sum  = longint'(x);
        for (int k = 1; k <= 8; k++) begin
            t2   = (term * x) >> 30;
            t2   = (t2 * x) >> 30;
            term = t2 / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) sum = sum - longint'(term);
            else            sum = sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        res = (sum + (longint'(1) <<< (29 - frac))) >>> (30 - frac);
        return 21'(res);
    endfunction

endpackage

@@ hdl/odm_trig.sv @@
// ----------------------------------------------------------------------------
// odm_trig: signed sine and cosine lookup
// Reduces a bearing to 0..359 and folds it onto the quarter-wave table.
// ----------------------------------------------------------------------------
module odm_trig import odm_pkg::*; #(
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic signed [9:0]               i_bearing,
    output logic signed [TRIG_FRAC_BITS+1:0] o_sin,
    output logic signed [TRIG_FRAC_BITS+1:0] o_cos
);
    localparam int TW = TRIG_FRAC_BITS + 2;

    logic [8:0]           n_red;
    logic [8:0]           r_red;
    logic [8:0]           w_cr;
    logic signed [TW-1:0] n_sin;
    logic signed [TW-1:0] n_cos;
    logic [TW-1:0]        w_tab [91];

    // quarter-wave table, fixed at elaboration
    for (genvar g = 0; g <= 90; g++) begin : g_tab
        localparam logic [TW-1:0] ENTRY = TW'(sin_entry(g, TRIG_FRAC_BITS));
        assign w_tab[g] = ENTRY;
    end

    always_comb begin
        if (i_bearing < 0)
            n_red = (i_bearing < -10'sd360) ? 9'(11'(i_bearing) + 11'sd720)
                                            : 9'(i_bearing + 10'sd360);
        else
            n_red = (i_bearing > 10'sd359) ? 9'(i_bearing - 10'sd360) : 9'(i_bearing);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_red <= n_red;
    end

    function automatic logic signed [TW-1:0] sdeg(input logic [8:0] r);
        logic signed [TW-1:0] v;
        int a;
        int d;
        a = int'(r);
        if (a <= 90)       d = a;
        else if (a <= 180) d = 180 - a;
        else if (a <= 270) d = a - 180;
        else               d = 360 - a;
        v = signed'(w_tab[7'(d)]);
        if (a > 180) v = -v;
        return v;
    endfunction

    assign w_cr  = (r_red >= 9'd270) ? r_red - 9'd270 : r_red + 9'd90;

    always_comb begin
        n_sin = sdeg(r_red);
        n_cos = sdeg(w_cr);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sin <= n_sin;
            o_cos <= n_cos;
        end
    end
endmodule

@@ hdl/odm_div.sv @@
// ----------------------------------------------------------------------------
// odm_div: pipelined signed divide, truncating toward zero
// One quotient bit a stage, dividend and divisor carried alongside.
// ----------------------------------------------------------------------------
module odm_div #(
    parameter int NW = 40,
    parameter int DW = 36,
    parameter int QW = 9
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [NW-1:0] i_num,
    input  logic        [DW-1:0] i_den,
    output logic signed [QW-1:0] o_quo
);
    // quotient magnitude reaches 256, so it needs QW bits
    localparam int QB = QW;

    logic [NW-1:0] r_rem [QB+1];
    logic [QB-1:0] r_q   [QB+1];
    logic [DW-1:0] r_den [QB+1];
    logic          r_neg [QB+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
            r_neg[0] <= i_num[NW-1];
            r_den[0] <= i_den;
            r_q[0]   <= '0;
        end
    end

    for (genvar s = 0; s < QB; s++) begin : g_stage
        localparam int B = QB - 1 - s;
        logic [NW+QB-1:0] w_sub;
        assign w_sub = (NW+QB)'(r_den[s]) << B;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if ((NW+QB)'(r_rem[s]) >= w_sub) begin
                    r_rem[s+1] <= NW'((NW+QB)'(r_rem[s]) - w_sub);
                    r_q[s+1]   <= r_q[s] | (QB'(1) << B);
                end else begin
                    r_rem[s+1] <= r_rem[s];
                    r_q[s+1]   <= r_q[s];
                end
                r_den[s+1] <= r_den[s];
                r_neg[s+1] <= r_neg[s];
            end
        end
    end

    assign o_quo = QW'(r_neg[QB] ? -$signed({1'b0, r_q[QB]}) : $signed({1'b0, r_q[QB]}));
endmodule

@@ hdl/omni_drive_mixer.sv @@
// ----------------------------------------------------------------------------
// omni_drive_mixer: four-wheel omni base speed mixer
// Turns one command word into one word of four wheel speeds.
// ----------------------------------------------------------------------------
// channel  | dir | fields
// s_axis   | in  | opcode, heading, speed, spin, ball x, four direct speeds
// m_axis   | out | four wheel speeds
// one word a cycle while m_axis accepts; registered stages in order: reduce, table,
// project, maximum, multiply-add, divider set-up, nine divide stages
// the whole pipe advances together; a stall on m_axis freezes every stage
// i_rst_n clears valid bits only
module omni_drive_mixer import odm_pkg::*; #(
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode[2:0] heading[12:3] speed[20:13] spin[28:21] ball_x[38:29]
    // dfr[46:39] dfl[54:47] dbr[62:55] dbl[70:63]
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // fr[8:0] fl[17:9] br[26:18] bl[35:27]
    output logic [39:0] m_axis_tdata
);
    localparam int TW  = TRIG_FRAC_BITS + 2;
    localparam int PW  = TW + 12;     // projection width
    localparam int NW  = PW + 10;     // numerator width
    localparam int LAT = 15;

    logic w_en;
    logic [LAT-1:0] r_vld;
    assign w_en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (w_en) r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
    end

    // stage 0: decode
    logic [2:0]        w_op;
    logic signed [9:0] w_head;
    logic signed [7:0] w_spd, w_spn;
    logic [9:0]        w_x;
    assign w_op   = s_axis_tdata[2:0];
    assign w_head = s_axis_tdata[12:3];
    assign w_spd  = s_axis_tdata[20:13];
    assign w_spn  = s_axis_tdata[28:21];
    assign w_x    = s_axis_tdata[38:29];

    logic signed [9:0] n_bear;
    logic signed [7:0] n_rot;
    logic              n_mix;
    logic [35:0]       n_fix;
    logic signed [8:0] w_turn;
    logic [6:0]        w_off;

    always_comb begin
        n_bear = w_head;
        n_rot  = w_spn;
        n_mix  = 1'b0;
        n_fix  = '0;
        w_off  = '0;
        w_turn = '0;
        case (w_op)
            OP_DIRECT: n_fix = {9'(signed'(s_axis_tdata[70:63])),
                                9'(signed'(s_axis_tdata[62:55])),
                                9'(signed'(s_axis_tdata[54:47])),
                                9'(signed'(s_axis_tdata[46:39]))};
            OP_VECTOR: n_mix = 1'b1;
            OP_CHASE: begin
                n_mix = 1'b1;
                n_rot = '0;
                if (w_x > 10'd350 && w_x < 10'd650) n_bear = '0;
                else begin
                    if (w_x > 10'd250 && w_x < 10'd750)      w_off = 7'd20;
                    else if (w_x > 10'd150 && w_x < 10'd850) w_off = 7'd10;
                    n_bear = (w_x < 10'd500) ? 10'sd50 - 10'(w_off)
                                             : 10'(w_off) - 10'sd50;
                end
            end
            OP_FACE: begin
                if (!(w_x > 10'd450 && w_x < 10'd550)) begin
                    if (w_x < 10'd500) begin
                        if (w_x > 10'd400)      w_off = 7'd50;
                        else if (w_x > 10'd300) w_off = 7'd25;
                        else if (w_x > 10'd200) w_off = 7'd10;
                        w_turn = 9'sd100 - 9'(w_off);
                    end else begin
                        if (w_x < 10'd600)      w_off = 7'd50;
                        else if (w_x < 10'd700) w_off = 7'd25;
                        else if (w_x < 10'd800) w_off = 7'd10;
                        w_turn = 9'(w_off) - 9'sd100;
                    end
                end
                n_fix = {w_turn, w_turn, w_turn, w_turn};
            end
            default: n_fix = '0;
        endcase
    end

    // side band: mix flag, fixed result, speed and spin along the pipe
    logic        r_mix [LAT];
    logic [35:0] r_fix [LAT];
    logic signed [7:0] r_spd [4];
    logic signed [7:0] r_rot [4];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mix[0] <= n_mix;
            r_fix[0] <= n_fix;
            r_spd[0] <= w_spd;
            r_rot[0] <= n_rot;
            for (int i = 1; i < LAT; i++) begin
                r_mix[i] <= r_mix[i-1];
                r_fix[i] <= r_fix[i-1];
            end
            for (int i = 1; i < 4; i++) begin
                r_spd[i] <= r_spd[i-1];
                r_rot[i] <= r_rot[i-1];
            end
        end
    end

    // stages 1,2: table (index registered inside)
    logic signed [TW-1:0] w_sin, w_cos;
    odm_trig #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig (
        .i_clk(i_clk), .i_en(w_en), .i_bearing(n_bear), .o_sin(w_sin), .o_cos(w_cos)
    );
    // trig output aligns with r_spd[1]

    // stage 3: projections
    logic signed [PW-1:0] r_p [4];
    logic signed [PW-1:0] w_s, w_c;
    assign w_s = PW'(w_sin) * PW'(WEIGHT_SIN);
    assign w_c = PW'(w_cos) * PW'(WEIGHT_COS);
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p[0] <= w_s + w_c;
            r_p[1] <= w_s - w_c;
            r_p[2] <= w_c - w_s;
            r_p[3] <= -w_s - w_c;
        end
    end

    // stage 4: maximum
    logic signed [PW-1:0] r_q [4];
    logic signed [PW-1:0] r_m, w_m01, w_m23;
    assign w_m01 = (r_p[1] > r_p[0]) ? r_p[1] : r_p[0];
    assign w_m23 = (r_p[3] > r_p[2]) ? r_p[3] : r_p[2];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_q <= r_p;
            r_m <= (w_m23 > w_m01) ? w_m23 : w_m01;
        end
    end

    // stage 5: numerators
    logic signed [NW-1:0] r_num [4];
    logic        [PW-1:0] r_den;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 4; i++)
                r_num[i] <= NW'(r_spd[3]) * NW'(r_q[i]) + NW'(r_rot[3]) * NW'(r_m);
            r_den <= (r_m > 0) ? PW'(r_m) : PW'(1);
        end
    end

    // stages 6..15: divide
    logic signed [8:0] w_quo [4];
    for (genvar g = 0; g < 4; g++) begin : g_div
        odm_div #(.NW(NW), .DW(PW), .QW(9)) u_div (
            .i_clk(i_clk), .i_en(w_en), .i_num(r_num[g]), .i_den(r_den),
            .o_quo(w_quo[g])
        );
    end

    assign m_axis_tdata = r_mix[LAT-1]
        ? {4'b0, w_quo[3], w_quo[2], w_quo[1], w_quo[0]}
        : {4'b0, r_fix[LAT-1]};
endmodule

@@ hdl/odm_checker.sv @@
// ----------------------------------------------------------------------------
// odm_checker: port-level checks for the mixer
// Handshake, padding and reset checks seen from the ports.
// ----------------------------------------------------------------------------
module odm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);
    // output word stays while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed under stall");
    // ready follows downstream
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while pipe stalled");
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[39:36] == 4'd0)
        else $error("padding bits set");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("valid after reset");
endmodule

bind omni_drive_mixer odm_checker u_chk (.*);
